### sv/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

    // Result status codes carried in the master-side tuser.
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

    // Request kinds carried in the slave-side tuser.
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [5:0] VAL_PLUS  = 6'd62;
    localparam logic [5:0] VAL_SLASH = 6'd63;

    // Job queue between front and back; the depth must be a power of two.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One queued job: up to three data bytes, optionally followed by an end status.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n_data;
        logic       has_end;
        logic [1:0] end_status;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [1:0] cnt;
        logic       err;
    } t_front_stat;

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [7:0] v;
        logic       bad;
        v   = 8'd0;
        bad = 1'b0;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            v = c - CH_UP_A;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            v = c - CH_LO_A + OFS_LOWER;
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            v = c - CH_DIG_0 + OFS_DIGIT;
        end else if (c == CH_PLUS) begin
            v = {2'b00, VAL_PLUS};
        end else if (c == CH_SLASH) begin
            v = {2'b00, VAL_SLASH};
        end else begin
            bad = 1'b1;
        end
        return {bad, v[5:0]};
    endfunction

endpackage
`default_nettype wire

### sv/b64d_front.sv
`default_nettype none
module b64d_front
    import b64d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // char_code
    input  wire logic [0:0]  i_s_tuser,   // req_type
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_job             o_job,
    output t_front_stat      o_stat
);

    logic [5:0] r_s0, r_s1, r_s2;
    logic [1:0] r_cnt, n_cnt;
    logic       r_err, n_err;

    logic       accept;
    logic [6:0] mapped;
    logic       skip;

    assign o_s_tready = !i_q_stat.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign mapped     = map_char(i_s_tdata);
    assign skip       = (i_s_tdata == CH_PAD) || (i_s_tdata == CH_LF) || (i_s_tdata == CH_CR);
    assign o_stat     = '{cnt: r_cnt, err: r_err};

    always_comb begin
        n_cnt            = r_cnt;
        n_err            = r_err;
        o_push           = 1'b0;
        o_job.b0         = {r_s0, r_s1[5:4]};
        o_job.b1         = {r_s1[3:0], r_s2[5:2]};
        o_job.b2         = {r_s2[1:0], mapped[5:0]};
        o_job.n_data     = 2'd0;
        o_job.has_end    = 1'b0;
        o_job.end_status = ST_OK;
        if (accept) begin
            if (i_s_tuser[0] == REQ_END) begin
                o_push        = 1'b1;
                o_job.has_end = 1'b1;
                if (r_err) begin
                    o_job.end_status = ST_BADCHAR;
                end else if (r_cnt == 2'd1) begin
                    o_job.end_status = ST_BADLEN;
                end else if (r_cnt == 2'd3) begin
                    o_job.n_data = 2'd2;
                end else if (r_cnt == 2'd2) begin
                    o_job.n_data = 2'd1;
                end
                n_cnt = 2'd0;
                n_err = 1'b0;
            end else if (!r_err && !skip) begin
                if (mapped[6]) begin
                    n_err = 1'b1;
                end else if (r_cnt == 2'd3) begin
                    o_push       = 1'b1;
                    o_job.n_data = 2'd3;
                    n_cnt        = 2'd0;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_err <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_err <= n_err;
        end
    end

    // Sextet store: written only while a character is taken into the group.
    always_ff @(posedge i_clk) begin
        if (accept && i_s_tuser[0] == REQ_CHAR && !r_err && !skip && !mapped[6]) begin
            case (r_cnt)
                2'd0:    r_s0 <= mapped[5:0];
                2'd1:    r_s1 <= mapped[5:0];
                2'd2:    r_s2 <= mapped[5:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/b64d_fifo.sv
`default_nettype none
module b64d_fifo
    import b64d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output t_job       o_job,
    output t_q_stat    o_stat
);

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### sv/b64d_back.sv
`default_nettype none
module b64d_back
    import b64d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_job        i_job,
    input  wire t_q_stat     i_q_stat,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // data_byte
    output logic [1:0]       o_m_tuser,   // status
    output logic             o_m_tlast    // last
);

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_idx;

    logic       is_status;
    logic       is_final;
    logic       take;

    assign is_status = r_job.has_end && (r_idx == r_job.n_data);
    assign is_final  = is_status || (!r_job.has_end && r_idx == 2'd2);
    assign take      = r_busy && i_m_tready;
    assign o_pop     = (!r_busy || (take && is_final)) && !i_q_stat.empty;

    assign o_m_tvalid = r_busy;
    assign o_m_tuser  = is_status ? r_job.end_status : ST_DATA;
    assign o_m_tlast  = is_status;

    always_comb begin
        case (r_idx)
            2'd0:    o_m_tdata = r_job.b0;
            2'd1:    o_m_tdata = r_job.b1;
            2'd2:    o_m_tdata = r_job.b2;
            default: o_m_tdata = 8'd0;
        endcase
        if (is_status) begin
            o_m_tdata = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (take && is_final) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule
`default_nettype wire

### sv/base64_stream_decoder.sv
`default_nettype none
// Streaming base64 decoder for the standard alphabet. Each request on the slave side
// carries one character in tdata, or, with tuser set, an end-of-text marker. Pad '=',
// CR and LF are skipped; every fourth alphabet character yields three decoded bytes on
// the master side, and the end-of-text marker flushes one or two leftover bytes and then
// returns a status result with tlast set (1 ok, 2 invalid character seen, 3 bad tail
// length; data results carry status 0). After an invalid character all further text is
// ignored until end of text, and every end of text clears the decoder. One request is
// accepted per cycle as long as the four-entry job queue has room; the job of a request
// passes through the queue and the back's job register before its first result appears.
// Results leave at one per cycle while the master is ready; each four-character group
// gives three and an end up to three, so a steady stream runs at one character per cycle.
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // char_code
    input  wire logic [0:0]  i_s_tuser,   // req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // data_byte
    output logic [1:0]       o_m_tuser,   // status
    output logic             o_m_tlast    // last
);

    logic        w_push;
    logic        w_pop;
    t_job        w_job_in;
    t_job        w_job_out;
    t_q_stat     w_q_stat;
    t_front_stat w_front_stat;

    // The front classifies characters, keeps the partial group and queues a job for
    // every request that produces results.
    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .o_stat     (w_front_stat)
    );

    // The queue decouples the two sides so that either may stall on its own.
    b64d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    // The back serialises each job into individual result requests.
    b64d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job_out),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // The front must never queue a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full))
        else $error("job pushed into a full queue");

    // An accepted end of text leaves the decoder cleared.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0] == REQ_END)
            |=> (w_front_stat.cnt == 2'd0 && !w_front_stat.err))
        else $error("end of text did not clear the decoder state");

    // Only the final status result of a run is marked last; data results are not.
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser != ST_DATA)))
        else $error("tlast does not match the result status");

    // Nothing is popped from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from an empty queue");

endmodule
`default_nettype wire
